// File: rtl/tsps_pkg.sv
package tsps_pkg;

    localparam int unsigned BURST_COUNT_DEF   = 8;
    localparam int unsigned UNREACH_LIMIT_DEF = 12;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 5;

    localparam logic [4:0]  MIN_POLL_RESET  = 5'd6;
    localparam logic [4:0]  MAX_POLL_RESET  = 5'd17;
    localparam logic [4:0]  HOST_POLL_RESET = 5'd6;
    localparam logic [31:0] BURST_SPACING   = 32'd2;
    localparam logic [7:0]  UNREACH_SAT     = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PEER_KIND     = 3'd0,
        CFG_INITIAL_BURST = 3'd1,
        CFG_BURST         = 3'd2,
        CFG_MIN_POLL      = 3'd3,
        CFG_MAX_POLL      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_ORDINARY     = 2'd0,
        KIND_BCAST_SERVER = 2'd1,
        KIND_BCAST_CLIENT = 2'd2,
        KIND_UNUSED       = 2'd3
    } peer_kind_t;

    localparam logic MODE_POLL  = 1'b0;
    localparam logic MODE_REPLY = 1'b1;

    typedef struct packed {
        logic [1:0] peer_kind;
        logic       initial_burst_enable;
        logic       burst_enable;
        logic [4:0] min_poll_exp;
        logic [4:0] max_poll_exp;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_seconds;
        logic [4:0]  system_poll_exp;
        logic [4:0]  peer_poll_exp;
        logic        system_synced;
        logic        peer_acceptable;
    } item_t;

    typedef struct packed {
        logic        transmit;
        logic        stuff_dispersion;
        logic [31:0] next_poll_time;
        logic [4:0]  host_poll_exp;
        logic [3:0]  burst_left;
        logic [7:0]  reach_bits;
        logic [7:0]  unreach_count;
    } result_t;

endpackage

// File: rtl/time_sync_poll_scheduler.sv
// a result word is computed combinationally and registered in the output buffer once its item word is accepted
// throughput: one item per cycle while item_stall is low, the core and the output register working in parallel
// a two-word output buffer keeps taking items while a result is held; item_stall
// rises only once both words are occupied
// reset clears peer state (host poll 6) and the registers to their defaults
module time_sync_poll_scheduler
    import tsps_pkg::*;
#(
    parameter int unsigned BURST_COUNT   = BURST_COUNT_DEF,
    parameter int unsigned UNREACH_LIMIT = UNREACH_LIMIT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    result_t core_result;
    logic    accept;
    logic    buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peer_kind            <= KIND_ORDINARY;
            cfg_reg.initial_burst_enable <= 1'b0;
            cfg_reg.burst_enable         <= 1'b0;
            cfg_reg.min_poll_exp         <= MIN_POLL_RESET;
            cfg_reg.max_poll_exp         <= MAX_POLL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PEER_KIND:     cfg_reg.peer_kind            <= cfg_data[1:0];
                CFG_INITIAL_BURST: cfg_reg.initial_burst_enable <= cfg_data[0];
                CFG_BURST:         cfg_reg.burst_enable         <= cfg_data[0];
                CFG_MIN_POLL:      cfg_reg.min_poll_exp         <= cfg_data;
                CFG_MAX_POLL:      cfg_reg.max_poll_exp         <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign item_stall = buf_full;
    assign accept     = item_valid && !buf_full;

    tsps_core #(
        .BURST_COUNT   (BURST_COUNT),
        .UNREACH_LIMIT (UNREACH_LIMIT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    tsps_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_word    (core_result),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/tsps_core.sv
module tsps_core
    import tsps_pkg::*;
#(
    parameter int unsigned BURST_COUNT   = BURST_COUNT_DEF,
    parameter int unsigned UNREACH_LIMIT = UNREACH_LIMIT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [7:0]  reach_reg, reach_next;
    logic [7:0]  unreach_reg, unreach_next;
    logic [3:0]  burst_reg, burst_next;
    logic [4:0]  host_poll_reg, host_poll_next;
    logic [31:0] last_poll_reg, last_poll_next;
    logic [31:0] next_time_reg, next_time_next;

    logic        xmit;
    logic        stuff;
    logic        do_sched;
    logic [5:0]  hexp;
    logic [5:0]  h_lo;
    logic [4:0]  host_clamped;
    logic [4:0]  p_lo;
    logic [4:0]  p_exp;
    logic [7:0]  shifted;
    logic [31:0] cand;
    logic        cand_valid;

    function automatic logic [7:0] bump(input logic [7:0] v);
        bump = (v < UNREACH_SAT) ? v + 8'd1 : v;
    endfunction

    always_comb
    begin
        reach_next     = reach_reg;
        unreach_next   = unreach_reg;
        burst_next     = burst_reg;
        last_poll_next = last_poll_reg;
        hexp           = {1'b0, host_poll_reg};
        xmit           = 1'b0;
        stuff          = 1'b0;
        do_sched       = 1'b0;
        shifted        = {reach_reg[6:0], 1'b0};

        if (item.mode == MODE_REPLY)
        begin
            reach_next = reach_reg | 8'd1;
        end
        else if (cfg.peer_kind == KIND_BCAST_SERVER)
        begin
            last_poll_next = item.now_seconds;
            xmit           = item.system_synced;
            do_sched       = 1'b1;
        end
        else
        begin
            if (burst_reg == 4'd0)
            begin
                last_poll_next = item.now_seconds;
                reach_next     = shifted;
                if (shifted == 8'd0)
                begin
                    // first miss may open a burst; otherwise back off once the limit is reached
                    if (cfg.initial_burst_enable && unreach_reg == 8'd0)
                    begin
                        burst_next   = 4'(BURST_COUNT);
                        unreach_next = bump(unreach_reg);
                    end
                    else if (unreach_reg < 8'(UNREACH_LIMIT))
                    begin
                        unreach_next = bump(bump(unreach_reg));
                    end
                    else
                    begin
                        hexp         = hexp + 6'd1;
                        unreach_next = bump(unreach_reg);
                    end
                end
                else
                begin
                    unreach_next = 8'd0;
                    stuff        = (shifted[2:0] == 3'd0);
                    hexp         = {1'b0, item.system_poll_exp};
                    if (cfg.burst_enable && item.peer_acceptable)
                    begin
                        burst_next = 4'(BURST_COUNT);
                    end
                end
            end
            else
            begin
                burst_next = burst_reg - 4'd1;
            end
            xmit     = (cfg.peer_kind != KIND_BCAST_CLIENT);
            do_sched = 1'b1;
        end
    end

    // clamp and next poll time
    always_comb
    begin
        h_lo         = (hexp < {1'b0, cfg.min_poll_exp}) ? {1'b0, cfg.min_poll_exp} : hexp;
        host_clamped = (h_lo > {1'b0, cfg.max_poll_exp}) ? cfg.max_poll_exp : h_lo[4:0];
        p_lo         = (item.peer_poll_exp < cfg.min_poll_exp) ? cfg.min_poll_exp
                                                               : item.peer_poll_exp;
        p_exp        = (host_clamped < p_lo) ? host_clamped : p_lo;

        cand       = last_poll_next + (32'd1 << p_exp);
        cand_valid = 1'b1;
        if (burst_next != 4'd0)
        begin
            // inside a burst the due time only moves when it is reached
            cand       = next_time_reg + BURST_SPACING;
            cand_valid = (item.now_seconds == next_time_reg);
        end

        host_poll_next = host_poll_reg;
        next_time_next = next_time_reg;
        if (do_sched)
        begin
            host_poll_next = host_clamped;
            if (cand_valid)
            begin
                next_time_next = (cand <= item.now_seconds) ? item.now_seconds + 32'd1 : cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg     <= 8'd0;
            unreach_reg   <= 8'd0;
            burst_reg     <= 4'd0;
            host_poll_reg <= HOST_POLL_RESET;
            last_poll_reg <= 32'd0;
            next_time_reg <= 32'd0;
        end
        else if (accept)
        begin
            reach_reg     <= reach_next;
            unreach_reg   <= unreach_next;
            burst_reg     <= burst_next;
            host_poll_reg <= host_poll_next;
            last_poll_reg <= last_poll_next;
            next_time_reg <= next_time_next;
        end
    end

    always_comb
    begin
        result.transmit         = xmit;
        result.stuff_dispersion = stuff;
        result.next_poll_time   = next_time_next;
        result.host_poll_exp    = host_poll_next;
        result.burst_left       = burst_next;
        result.reach_bits       = reach_next;
        result.unreach_count    = unreach_next;
    end

endmodule

// File: rtl/tsps_out_buf.sv
module tsps_out_buf
    import tsps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = out_valid_reg && !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                // output word still waiting, park the new one
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: rtl/tsps_checker.sv
module tsps_checker
    import tsps_pkg::*;
#(
    parameter int unsigned BURST_COUNT = BURST_COUNT_DEF
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // input back-pressure only follows a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(result_valid && result_stall))
        else $error("item_stall raised without output back-pressure");

    // an accepted item always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("accepted item produced no result word");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.burst_left <= 4'(BURST_COUNT))
        else $error("burst count beyond its load value");

    // stuffing only on a reachable poll whose last three polls went unanswered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stuff_dispersion |->
            result.unreach_count == 8'd0 && result.reach_bits[2:0] == 3'd0
            && result.reach_bits != 8'd0)
        else $error("dispersion stuffing on an unexpected poll");

endmodule

bind time_sync_poll_scheduler tsps_checker #(
    .BURST_COUNT (BURST_COUNT)
) u_tsps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: sim/time_sync_poll_scheduler_tb.sv
module time_sync_poll_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item_word    = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result_word;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // scheduler state as the testbench expects it
    cfg_t        peer_cfg;
    logic [7:0]  reach_m;
    logic [7:0]  unreach_m;
    logic [3:0]  burst_m;
    logic [4:0]  host_m;
    logic [31:0] last_m;
    logic [31:0] due_m;

    result_t     pending_results[$];
    bit          valid_up;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned faults;
    int unsigned cycles;
    int unsigned n_items;
    int unsigned n_replies;
    int unsigned n_results;
    int unsigned n_cfg;
    int unsigned n_bursts;
    int unsigned n_saturated;
    int unsigned n_top_exp;

    time_sync_poll_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == UNREACH_SAT) ? v : v + 8'd1;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("xmit %0d stuff %0d next %08h host %0d burst %0d reach %02h unreach %0d",
                         r.transmit, r.stuff_dispersion, r.next_poll_time, r.host_poll_exp,
                         r.burst_left, r.reach_bits, r.unreach_count);
    endfunction

    task automatic reset_peer_model();
        peer_cfg  = cfg_t'{KIND_ORDINARY, 1'b0, 1'b0, MIN_POLL_RESET, MAX_POLL_RESET};
        reach_m   = '0;
        unreach_m = '0;
        burst_m   = '0;
        host_m    = HOST_POLL_RESET;
        last_m    = '0;
        due_m     = '0;
    endtask

    // clamp the host exponent, then work out when the next poll falls due
    function automatic void plan_next_poll(input logic [31:0] now, input int unsigned hexp,
                                           input logic [4:0] pexp);
        int unsigned lo;
        int unsigned hi;
        int unsigned h;
        int unsigned p;
        lo = peer_cfg.min_poll_exp;
        hi = peer_cfg.max_poll_exp;
        h = (hexp < lo) ? lo : hexp;
        host_m = 5'((h > hi) ? hi : h);
        if (burst_m != 4'd0)
        begin
            // inside a burst the due time only moves when polled exactly on it
            if (now != due_m)
                return;
            due_m = due_m + BURST_SPACING;
        end
        else
        begin
            p = (pexp < lo) ? lo : pexp;
            if (host_m < p)
                p = host_m;
            due_m = last_m + (32'd1 << p);
        end
        if (due_m <= now)
            due_m = now + 32'd1;
    endfunction

    task automatic update_peer_model(input item_t w);
        int unsigned hexp;
        result_t     r;
        r = '0;
        hexp = host_m;
        n_items++;
        if (w.mode == MODE_REPLY)
        begin
            reach_m = reach_m | 8'd1;
            n_replies++;
        end
        else if (peer_cfg.peer_kind == KIND_BCAST_SERVER)
        begin
            last_m = w.now_seconds;
            r.transmit = w.system_synced;
            plan_next_poll(w.now_seconds, hexp, w.peer_poll_exp);
        end
        else
        begin
            if (burst_m == 4'd0)
            begin
                last_m = w.now_seconds;
                reach_m = reach_m << 1;
                if (reach_m == 8'd0)
                begin
                    if (peer_cfg.initial_burst_enable && unreach_m == 8'd0)
                    begin
                        burst_m = 4'(BURST_COUNT_DEF);
                        n_bursts++;
                    end
                    else if (unreach_m < UNREACH_LIMIT_DEF)
                        unreach_m = sat_inc(unreach_m);
                    else
                        hexp++;
                    // second increment is deliberate
                    unreach_m = sat_inc(unreach_m);
                    if (unreach_m == UNREACH_SAT)
                        n_saturated++;
                    if (hexp > 31)
                        n_top_exp++;
                end
                else
                begin
                    unreach_m = 8'd0;
                    r.stuff_dispersion = (reach_m[2:0] == 3'b000);
                    hexp = w.system_poll_exp;
                    if (peer_cfg.burst_enable && w.peer_acceptable)
                    begin
                        burst_m = 4'(BURST_COUNT_DEF);
                        n_bursts++;
                    end
                end
            end
            else
                burst_m = burst_m - 4'd1;
            r.transmit = (peer_cfg.peer_kind != KIND_BCAST_CLIENT);
            plan_next_poll(w.now_seconds, hexp, w.peer_poll_exp);
        end
        r.next_poll_time = due_m;
        r.host_poll_exp  = host_m;
        r.burst_left     = burst_m;
        r.reach_bits     = reach_m;
        r.unreach_count  = unreach_m;
        pending_results.push_back(r);
    endtask

    task automatic send_word(input item_t w);
        // each cycle the sender may sit idle with the given odds
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            if (valid_up)
                item_valid <= 1'b0;
            valid_up = 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_word  <= w;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        update_peer_model(w);
    endtask

    task automatic wait_idle();
        if (valid_up)
            item_valid <= 1'b0;
        valid_up = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        write_reg(CFG_PEER_KIND, CFG_DATA_W'(c.peer_kind));
        write_reg(CFG_INITIAL_BURST, CFG_DATA_W'(c.initial_burst_enable));
        write_reg(CFG_BURST, CFG_DATA_W'(c.burst_enable));
        write_reg(CFG_MIN_POLL, c.min_poll_exp);
        write_reg(CFG_MAX_POLL, c.max_poll_exp);
        cfg_we <= 1'b0;
        peer_cfg = c;
        n_cfg += 5;
    endtask

    // polls mostly land on the scheduled time so that bursts keep their spacing
    function automatic item_t rand_word(input int unsigned reply_pct);
        item_t       w;
        int unsigned pick;
        w.mode = ($urandom_range(99) < reply_pct) ? MODE_REPLY : MODE_POLL;
        pick = $urandom_range(99);
        if (pick < 55)
            w.now_seconds = due_m;
        else if (pick < 75)
            w.now_seconds = due_m + 32'($urandom_range(3)) - 32'd1;
        else if (pick < 90)
            w.now_seconds = $urandom;
        else
            w.now_seconds = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        w.system_poll_exp = 5'($urandom_range(31));
        w.peer_poll_exp   = 5'($urandom_range(31));
        w.system_synced   = 1'($urandom_range(1));
        w.peer_acceptable = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t        c;
        int unsigned r;
        c.peer_kind = ($urandom_range(99) < 50) ? KIND_ORDINARY : 2'($urandom_range(3));
        c.initial_burst_enable = 1'($urandom_range(1));
        c.burst_enable = 1'($urandom_range(1));
        r = $urandom_range(99);
        c.min_poll_exp = (r < 15) ? 5'd0 : (r < 25) ? 5'd31 : 5'($urandom_range(10));
        r = $urandom_range(99);
        c.max_poll_exp = (r < 20) ? 5'd31 : (r < 30) ? 5'd0 : 5'($urandom_range(31, 8));
        return c;
    endfunction

    task automatic test_reply_and_reachable();
        send_word(item_t'{MODE_REPLY, 32'hFFFF_FFFF, 5'd31, 5'd31, 1'b1, 1'b1});
        send_word(item_t'{MODE_POLL, 32'h0, 5'd31, 5'd0, 1'b0, 1'b0});
        // due time wraps past zero and is pulled forward to now + 1
        send_word(item_t'{MODE_POLL, 32'hFFFF_FFFF, 5'd0, 5'd31, 1'b1, 1'b1});
        // no reply in the last three polls, so dispersion gets stuffed
        send_word(item_t'{MODE_POLL, due_m, 5'd5, 5'd5, 1'b0, 1'b1});
    endtask

    task automatic test_peer_kinds();
        wait_idle();
        set_config(cfg_t'{KIND_BCAST_SERVER, 1'b1, 1'b1, MIN_POLL_RESET, MAX_POLL_RESET});
        send_word(item_t'{MODE_POLL, due_m, 5'd9, 5'd4, 1'b0, 1'b1});
        send_word(item_t'{MODE_POLL, due_m, 5'd9, 5'd4, 1'b1, 1'b1});
        wait_idle();
        set_config(cfg_t'{KIND_BCAST_CLIENT, 1'b0, 1'b0, MIN_POLL_RESET, MAX_POLL_RESET});
        send_word(item_t'{MODE_POLL, due_m, 5'd9, 5'd4, 1'b1, 1'b0});
        send_word(item_t'{MODE_REPLY, due_m, 5'd9, 5'd4, 1'b1, 1'b0});
        wait_idle();
        set_config(cfg_t'{KIND_UNUSED, 1'b0, 1'b0, MIN_POLL_RESET, MAX_POLL_RESET});
        send_word(item_t'{MODE_POLL, due_m, 5'd9, 5'd4, 1'b0, 1'b0});
    endtask

    task automatic test_bursts();
        int unsigned k;
        wait_idle();
        set_config(cfg_t'{KIND_ORDINARY, 1'b1, 1'b1, 5'd0, 5'd31});
        k = 0;
        // let the reach register empty out until the initial burst fires
        while (burst_m == 4'd0 && k < 9)
        begin
            send_word(item_t'{MODE_POLL, due_m, 5'd3, 5'd2, 1'b1, 1'b0});
            k++;
        end
        send_word(item_t'{MODE_POLL, due_m, 5'd3, 5'd2, 1'b1, 1'b0});
        send_word(item_t'{MODE_POLL, due_m + 32'd7, 5'd3, 5'd2, 1'b1, 1'b0});
        send_word(item_t'{MODE_REPLY, due_m, 5'd3, 5'd2, 1'b1, 1'b0});
        send_word(item_t'{MODE_POLL, due_m, 5'd3, 5'd2, 1'b1, 1'b1});
    endtask

    task automatic test_clamp_limits();
        wait_idle();
        // lower clamp above upper clamp: the upper one wins
        set_config(cfg_t'{KIND_ORDINARY, 1'b0, 1'b1, 5'd31, 5'd0});
        send_word(item_t'{MODE_REPLY, due_m, 5'd31, 5'd31, 1'b0, 1'b1});
        send_word(item_t'{MODE_POLL, due_m, 5'd31, 5'd31, 1'b0, 1'b1});
        send_word(item_t'{MODE_POLL, due_m, 5'd0, 5'd0, 1'b1, 1'b0});
    endtask

    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned sent;
        int unsigned seg_end;
        int unsigned run;
        int unsigned reply_pct;
        int unsigned pick;
        sent = 0;
        for (int seg = 1; seg <= 4; seg++)
        begin
            wait_idle();
            set_config(rand_cfg());
            seg_end = (n_words * seg) / 4;
            while (sent < seg_end)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    reply_pct = 45;
                    run = $urandom_range(20, 5);
                end
                else if (pick < 90)
                begin
                    // outage: the peer stops answering
                    reply_pct = 0;
                    run = $urandom_range(30, 5);
                end
                else
                begin
                    reply_pct = 70;
                    run = $urandom_range(8, 1);
                end
                repeat (run) send_word(rand_word(reply_pct));
                sent += run;
            end
        end
    endtask

    task automatic test_long_outage();
        wait_idle();
        // long enough for the exponent to hit the top and the count to saturate
        set_config(cfg_t'{KIND_ORDINARY, 1'b0, 1'b0, 5'($urandom_range(6)), 5'd31});
        repeat (280) send_word(rand_word(0));
        repeat (12) send_word(rand_word(50));
    endtask

    task automatic note_fault(input string what, input result_t want, input result_t got);
        faults++;
        if (faults <= 10)
        begin
            $display("[%0t] %s", $realtime, what);
            $display("    expected %s", fmt_result(want));
            $display("    actual   %s", fmt_result(got));
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("time_sync_poll_scheduler regression: fail");
            $finish;
        end
        else
        begin
            if (rst_n && result_valid && !result_stall)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    note_fault("result word with nothing expected", '0, result_word);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_word !== want)
                        note_fault("result word mismatch", want, result_word);
                end
            end
            result_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        reset_peer_model();
        valid_up = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 80;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reply_and_reachable();
        test_peer_kinds();
        test_bursts();
        test_clamp_limits();
        test_random_traffic(330);

        wait_idle();
        send_idle_pct = 80;
        recv_idle_pct = 15;
        test_random_traffic(330);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_outage();
        test_random_traffic(100);

        wait_idle();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            faults += pending_results.size();
            $display("%0d expected result words never arrived", pending_results.size());
        end
        $display("covered %0d item words (%0d replies), %0d result words, %0d register writes",
                 n_items, n_replies, n_results, n_cfg);
        $display("bursts started %0d, polls at saturated count %0d, exponent overflows %0d",
                 n_bursts, n_saturated, n_top_exp);
        if (faults == 0)
            $display("time_sync_poll_scheduler regression: pass");
        else
            $display("time_sync_poll_scheduler regression: fail");
        $finish;
    end

endmodule
